### rtl/core/lcdfr_pkg.sv
package lcdfr_pkg;

  // Fixed bytes of the update stream
  localparam logic [7:0] CMD_UPDATE = 8'h01;
  localparam logic [7:0] DUMMY_BYTE = 8'hFF;

  // Configuration register indexes
  localparam logic CFG_START_ROW  = 1'b0;
  localparam logic CFG_LINE_COUNT = 1'b1;

  // Request queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Classified request: one pixel byte plus what surrounds it
  typedef struct packed {
    logic [7:0] data;
    logic [7:0] addr;      // line address of the byte's line
    logic       head;      // frame opens: command and address go first
    logic       tail;      // line closes: dummy and next address follow
    logic       fend;      // closing line is the frame's last
  } desc_t;

  typedef struct packed {
    logic [6:0] start_row;
    logic [7:0] line_count;
  } cfg_t;

endpackage

### rtl/core/lcdfr_front.sv
module lcdfr_front
  import lcdfr_pkg::*;
#(
  parameter int BYTES_PER_LINE = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_pixel_byte,
  output logic       push,
  output desc_t      push_desc,
  input  logic       q_full
);

  localparam int LEN   = (BYTES_PER_LINE < 2) ? 2 : BYTES_PER_LINE;
  localparam int BIL_W = $clog2(LEN);

  logic [BIL_W-1:0] bil_r, bil_nxt;
  logic [7:0]       ld_r, ld_nxt;
  logic [7:0]       count;
  logic [BIL_W:0]   bil_inc;
  logic             head, tail, fend;

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  // Classify the byte against the frame position
  always_comb begin
    count   = (cfg.line_count == 8'd0) ? 8'd1 : cfg.line_count;
    bil_inc = {1'b0, bil_r} + {{BIL_W{1'b0}}, 1'b1};
    head    = (bil_r == '0) && (ld_r == 8'd0);
    tail    = bil_inc >= (BIL_W+1)'(LEN);
    fend    = ({1'b0, ld_r} + 9'd1) >= {1'b0, count};
    push_desc.data = in_pixel_byte;
    push_desc.addr = 8'({1'b0, cfg.start_row}) + 8'd1 + ld_r;
    push_desc.head = head;
    push_desc.tail = tail;
    push_desc.fend = fend;
  end

  // Advance the line position
  always_comb begin
    bil_nxt = bil_r;
    ld_nxt  = ld_r;
    if (push) begin
      if (tail) begin
        bil_nxt = '0;
        ld_nxt  = fend ? 8'd0 : ld_r + 8'd1;
      end else begin
        bil_nxt = bil_inc[BIL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bil_r <= '0;
      ld_r  <= 8'd0;
    end else begin
      bil_r <= bil_nxt;
      ld_r  <= ld_nxt;
    end
  end

endmodule

### rtl/core/lcdfr_queue.sv
module lcdfr_queue
  import lcdfr_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  desc_t push_desc,
  input  logic  pop,
  output desc_t head_desc,
  output logic  empty,
  output logic  full
);

  desc_t              mem [QDEPTH];
  logic [QPTR_W-1:0]  wptr_r, wptr_nxt;
  logic [QPTR_W-1:0]  rptr_r, rptr_nxt;
  logic [QCNT_W-1:0]  cnt_r, cnt_nxt;

  assign empty     = (cnt_r == '0);
  assign full      = (cnt_r == QCNT_W'(QDEPTH));
  assign head_desc = mem[rptr_r];

  // Wrap pointers and track the fill level
  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (push) begin
      wptr_nxt = (wptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (pop) begin
      rptr_nxt = (rptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Store the request
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr_r] <= push_desc;
    end
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty) else $error("queue popped while empty");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full) else $error("queue pushed while full");

endmodule

### rtl/core/lcdfr_back.sv
module lcdfr_back
  import lcdfr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  desc_t      head_desc,
  input  logic       empty,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_frame_end,
  output logic       out_last
);

  logic [1:0] ph_r, ph_nxt;
  logic       ov_r, ov_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic       fe_r, fe_nxt;
  logic       last_r, last_nxt;
  logic       load, final_ph;

  assign out_valid     = ov_r;
  assign out_byte      = byte_r;
  assign out_frame_end = fe_r;
  assign out_last      = last_r;

  assign load     = !empty && (!ov_r || out_ready);
  assign final_ph = (head_desc.head || head_desc.tail) ? (ph_r == 2'd2) : 1'b1;
  assign pop      = load && final_ph;

  // Pick the byte for the current phase of the request
  always_comb begin
    byte_nxt = byte_r;
    fe_nxt   = fe_r;
    last_nxt = last_r;
    ov_nxt   = ov_r && !out_ready;
    ph_nxt   = ph_r;
    if (load) begin
      ov_nxt   = 1'b1;
      last_nxt = final_ph;
      fe_nxt   = 1'b0;
      ph_nxt   = final_ph ? 2'd0 : ph_r + 2'd1;
      case (ph_r)
        2'd0: byte_nxt = head_desc.head ? CMD_UPDATE : head_desc.data;
        2'd1: byte_nxt = head_desc.head ? head_desc.addr : DUMMY_BYTE;
        default: begin
          if (head_desc.head) begin
            byte_nxt = head_desc.data;
          end else if (head_desc.fend) begin
            byte_nxt = DUMMY_BYTE;
            fe_nxt   = 1'b1;
          end else begin
            byte_nxt = head_desc.addr + 8'd1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
      ph_r <= 2'd0;
    end else begin
      ov_r <= ov_nxt;
      ph_r <= ph_nxt;
    end
  end

  // Hold the payload until taken
  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    fe_r   <= fe_nxt;
    last_r <= last_nxt;
  end

  a_fe_trailer: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && fe_r) |-> (last_r && byte_r == DUMMY_BYTE))
    else $error("frame end not on a final dummy byte");

  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    ph_r != 2'd3) else $error("phase out of range");

endmodule

### rtl/core/memory_lcd_line_update_framer_core.sv
// Memory LCD line update framer.
// Input channel (in_valid/in_ready/in_pixel_byte) takes frame-buffer bytes in
// line order. Output channel (out_valid/out_ready) gives serial bytes, one or
// three per request, with out_frame_end on the closing dummy byte of a frame
// and out_last on the final byte caused by each input byte.
// A frame opens with the update command and the first line address; each line
// closes with a dummy byte and then the next address or a final dummy byte.
// Configuration (cfg_we/cfg_index/cfg_wdata) sets start_row and line_count; the
// user is to write it only while the block is idle, which the block itself does
// not enforce; it applies to the next input byte. The first output byte passes
// the queue write, then the output register load. Throughput: one output byte
// per cycle while out_ready is high, set by the output register; an input byte
// gives one output byte, or three for a frame's first byte and a line's last.
// A two-entry request queue between the front classifier and the back
// sequencer keeps input flowing while a result waits. When out_ready is low the
// output holds and the queue fills, then in_ready drops. Reset clears the line
// position, empties the queue and sets start_row to 0 and line_count to 128.
module memory_lcd_line_update_framer_core
  import lcdfr_pkg::*;
#(
  parameter int BYTES_PER_LINE = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_pixel_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_frame_end,
  output logic       out_last
);

  cfg_t  cfg_r;
  logic  push, pop, q_empty, q_full;
  desc_t push_desc, head_desc;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_row  <= 7'd0;
      cfg_r.line_count <= 8'd128;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_START_ROW:  cfg_r.start_row  <= cfg_wdata[6:0];
        CFG_LINE_COUNT: cfg_r.line_count <= cfg_wdata;
        default: ;
      endcase
    end
  end

  lcdfr_front #(
    .BYTES_PER_LINE(BYTES_PER_LINE)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_pixel_byte(in_pixel_byte),
    .push         (push),
    .push_desc    (push_desc),
    .q_full       (q_full)
  );

  lcdfr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_desc(push_desc),
    .pop      (pop),
    .head_desc(head_desc),
    .empty    (q_empty),
    .full     (q_full)
  );

  lcdfr_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head_desc    (head_desc),
    .empty        (q_empty),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .out_frame_end(out_frame_end),
    .out_last     (out_last)
  );

endmodule
